FILE: src/modulated_delay_chorus_core_macros.svh
// assertion macros for the chorus core
// each macro takes a label, clock, reset, antecedent, consequent and message
`ifndef MODULATED_DELAY_CHORUS_CORE_MACROS_SVH
`define MODULATED_DELAY_CHORUS_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define MDC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define MDC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define MDC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)

`define MDC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

FILE: src/mdc_pkg.sv
package mdc_pkg;

  // parameter defaults
  localparam int DELAY_DEPTH_DEF  = 4096;
  localparam int SAMPLE_BITS_DEF  = 16;
  localparam int SINE_ENTRIES_DEF = 1024;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_BASE_DELAY    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MOD_DEPTH     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_PHASE_STEP    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_WET_MIX       = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_FEEDBACK_GAIN = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_LPF_ALPHA     = 3'd5;

  // register reset values
  localparam logic [11:0] BASE_DELAY_RST = 12'd960;
  localparam logic [15:0] WET_MIX_RST    = 16'd32768;
  localparam int          WP_RESET       = 960;

  // delay lower limit in q.8 samples, keeps all taps in written history
  localparam int D_MIN = 513;

  // unity for q0.16 gains
  localparam logic [16:0] GAIN_ONE = 17'h10000;

  // sine polynomial constants, q0.14 argument
  localparam logic [14:0] SIN_ONE = 15'd16384;
  localparam logic [15:0] SIN_C1  = 16'd2383;
  localparam logic [15:0] SIN_C2  = 16'd21055;
  localparam logic [15:0] SIN_C3  = 16'd51459;
  localparam logic [16:0] SIN_MAX = 17'd32767;

  // sequencer states, one-hot
  typedef enum logic [21:0] {
    ST_CLEAR = 22'h000001,
    ST_IDLE  = 22'h000002,
    ST_SIN1  = 22'h000004,
    ST_SIN2  = 22'h000008,
    ST_SIN3  = 22'h000010,
    ST_SIN4  = 22'h000020,
    ST_DMUL  = 22'h000040,
    ST_DPOS  = 22'h000080,
    ST_RD0   = 22'h000100,
    ST_RD1   = 22'h000200,
    ST_RD2   = 22'h000400,
    ST_RD3   = 22'h000800,
    ST_RD4   = 22'h001000,
    ST_COEF  = 22'h002000,
    ST_H1    = 22'h004000,
    ST_H2    = 22'h008000,
    ST_H3    = 22'h010000,
    ST_Y     = 22'h020000,
    ST_W1    = 22'h040000,
    ST_W2    = 22'h080000,
    ST_O1    = 22'h100000,
    ST_O2    = 22'h200000
  } state_t;

endpackage

FILE: src/modulated_delay_chorus_core.sv
// channel  direction  signals                              transaction
// cfg      in         cfg_wen, cfg_addr, cfg_wdata         write when cfg_wen high
// s        in         s_tvalid, s_tready, s_tdata          one input sample
// m        out        m_tvalid, m_tready, m_tdata          one mixed output sample
//
// one sample at a time: the next is accepted only after the last leaves the sequencer, which
// runs through sine polynomial, delay position, four reads on the
// single read port of the delay memory, hermite steps and the mix steps
// after reset a clearing pass writes zeros through the delay memory with s_tready
// low; configuration writes are taken as ever
// a result waits in the output register, the next sample is accepted meanwhile and
// the sequencer holds in its last step while the output register is still full
`include "modulated_delay_chorus_core_macros.svh"

module modulated_delay_chorus_core #(
  parameter int DELAY_DEPTH  = mdc_pkg::DELAY_DEPTH_DEF,
  parameter int SAMPLE_BITS  = mdc_pkg::SAMPLE_BITS_DEF,
  parameter int SINE_ENTRIES = mdc_pkg::SINE_ENTRIES_DEF,
  localparam int TDW = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_wen,
  input  logic [mdc_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [mdc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  // input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [TDW-1:0]                  s_tdata,   // [SAMPLE_BITS-1:0] in_sample
  // output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [TDW-1:0]                  m_tdata    // [SAMPLE_BITS-1:0] out_sample
);

  localparam int S    = SAMPLE_BITS;
  localparam int AW   = $clog2(DELAY_DEPTH);
  localparam int KB   = $clog2(SINE_ENTRIES);
  localparam int DW   = (AW + 10 > 22) ? AW + 10 : 22;  // q.8 delay, signed
  localparam int CW   = S + 4;                           // hermite coefficients
  localparam int HW   = S + 32;                          // hermite accumulator
  localparam int SATW = S + 8;                           // saturation input
  localparam int MW   = S + 19;                          // mix accumulator

  localparam logic signed [SATW-1:0] SMAX_W = SATW'((1 << (S - 1)) - 1);
  localparam logic signed [SATW-1:0] SMIN_W = -SMAX_W - SATW'(1);
  localparam logic signed [DW-1:0]   DMIN   = DW'(mdc_pkg::D_MIN);
  localparam logic signed [DW-1:0]   DMAX   = DW'((DELAY_DEPTH - 1) * 256);
  localparam logic signed [AW+1:0]   DEPTH_S = (AW + 2)'(DELAY_DEPTH);
  localparam logic [AW-1:0]          WP_RST  = AW'(mdc_pkg::WP_RESET % DELAY_DEPTH);
  localparam logic [AW-1:0]          LAST_ADDR = AW'(DELAY_DEPTH - 1);
  localparam logic signed [HW-1:0]   H_ROUND = HW'(1 << 24);

  function automatic logic [S-1:0] sat_s(input logic signed [SATW-1:0] v);
    logic signed [SATW-1:0] r;
    priority if (v > SMAX_W) begin
      r = SMAX_W;
    end else if (v < SMIN_W) begin
      r = SMIN_W;
    end else begin
      r = v;
    end
    return r[S-1:0];
  endfunction

  // configuration registers
  logic [11:0] base_delay;
  logic [15:0] mod_depth;
  logic [31:0] phase_step;
  logic [15:0] wet_mix;
  logic [15:0] feedback_gain;
  logic [15:0] lpf_alpha;

  // block state
  mdc_pkg::state_t state;
  logic [AW-1:0]   clr_addr;
  logic [AW-1:0]   wp;
  logic [31:0]     phase;
  logic signed [S-1:0] lp;

  // per-sample working registers
  logic signed [S-1:0]  x_q;
  logic [14:0]          sx;
  logic [1:0]           squad;
  logic [14:0]          sx2;
  logic [15:0]          st;
  logic signed [15:0]   sine_q;
  logic signed [32:0]   dprod;
  logic [AW-1:0]        tap_base;
  logic [7:0]           f_q;
  logic signed [S-1:0]  p0, p1, p2, p3;
  logic signed [CW-1:0] c1, c2, c3;
  logic signed [HW-1:0] h;
  logic signed [S-1:0]  y_q;
  logic signed [MW-1:0] macc;
  logic [S-1:0]         out_q;
  logic                 m_valid;
  logic                 out_load;

  // delay memory ports
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [S-1:0]  wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [S-1:0]  rd_data;

  assign s_tready = (state == mdc_pkg::ST_IDLE);
  assign m_tvalid = m_valid;
  assign m_tdata  = TDW'(out_q);

  // final step hands over once the output register is free
  assign out_load = (state == mdc_pkg::ST_O2) && (!m_valid || m_tready);

  // ---------------------------------------------------------------------------
  // sine polynomial, one shared 15x16 multiplier over four steps
  // ---------------------------------------------------------------------------
  logic [15:0] u;
  logic [14:0] x_c;
  logic [14:0] sm_a;
  logic [15:0] sm_b;
  logic [30:0] sm_prod;
  logic [16:0] sm_sh;
  logic [14:0] s_mag;

  // angle from the top phase bits, mirrored in odd quadrants
  assign u   = {phase[31 -: KB], {(16 - KB){1'b0}}};
  assign x_c = u[14] ? 15'(mdc_pkg::SIN_ONE - {1'b0, u[13:0]}) : {1'b0, u[13:0]};

  always_comb begin
    sm_a = sx2;
    sm_b = st;
    unique case (state)
      mdc_pkg::ST_SIN1: begin
        sm_a = x_c;
        sm_b = {1'b0, x_c};
      end
      mdc_pkg::ST_SIN2: sm_b = mdc_pkg::SIN_C1;
      mdc_pkg::ST_SIN4: sm_a = sx;
      default: ;
    endcase
  end

  assign sm_prod = 31'(sm_a) * 31'(sm_b);
  assign sm_sh   = sm_prod[30:14];
  assign s_mag   = (sm_sh > mdc_pkg::SIN_MAX) ? mdc_pkg::SIN_MAX[14:0] : sm_sh[14:0];

  // ---------------------------------------------------------------------------
  // delay position and tap base
  // ---------------------------------------------------------------------------
  logic signed [DW-1:0]  d_raw, d_cl;
  logic [AW-1:0]         d_int;
  logic [7:0]            d_frac;
  logic signed [AW+1:0]  pos, pos_w;

  always_comb begin
    d_raw = DW'($signed({1'b0, base_delay, 8'h00})) + DW'(dprod >>> 15);
    priority if (d_raw < DMIN) begin
      d_cl = DMIN;
    end else if (d_raw > DMAX) begin
      d_cl = DMAX;
    end else begin
      d_cl = d_raw;
    end
    d_int  = d_cl[AW+7:8];
    d_frac = d_cl[7:0];
    // a fractional delay rounds the tap index one further back
    pos = $signed({2'b00, wp}) - $signed({2'b00, d_int})
          - ((d_frac != 8'h00) ? (AW + 2)'(1) : (AW + 2)'(0));
    pos_w = (pos < 0) ? pos + DEPTH_S : pos;
  end

  // ---------------------------------------------------------------------------
  // tap address around the base, wrapped into the memory
  // ---------------------------------------------------------------------------
  logic signed [AW+1:0] tap_off, tap_i, tap_w;

  always_comb begin
    unique case (state)
      mdc_pkg::ST_RD0: tap_off = -(AW + 2)'(1);
      mdc_pkg::ST_RD2: tap_off = (AW + 2)'(1);
      mdc_pkg::ST_RD3: tap_off = (AW + 2)'(2);
      default:         tap_off = (AW + 2)'(0);
    endcase
    tap_i = $signed({2'b00, tap_base}) + tap_off;
    priority if (tap_i < 0) begin
      tap_w = tap_i + DEPTH_S;
    end else if (tap_i >= DEPTH_S) begin
      tap_w = tap_i - DEPTH_S;
    end else begin
      tap_w = tap_i;
    end
  end

  assign rd_en   = (state == mdc_pkg::ST_RD0) || (state == mdc_pkg::ST_RD1) ||
                   (state == mdc_pkg::ST_RD2) || (state == mdc_pkg::ST_RD3);
  assign rd_addr = tap_w[AW-1:0];

  // ---------------------------------------------------------------------------
  // hermite steps, one shared multiply by the tap fraction
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] e0, e1, e2, e3, d12;
  logic signed [HW-1:0] h_in;
  logic signed [HW-1:0] hmul;
  logic signed [8:0]    fs;
  logic signed [HW-1:0] hr;
  logic signed [SATW-1:0] y_wide;

  assign e0  = CW'(p0);
  assign e1  = CW'(p1);
  assign e2  = CW'(p2);
  assign e3  = CW'(p3);
  assign d12 = e1 - e2;
  assign fs  = $signed({1'b0, f_q});
  assign h_in = (state == mdc_pkg::ST_H1) ? HW'(c3) : h;
  assign hmul = HW'(h_in * fs);
  assign hr   = (h + H_ROUND) >>> 25;
  assign y_wide = SATW'(p1) + SATW'(hr);

  // ---------------------------------------------------------------------------
  // gain mix: one q0.16 gain times one sample per step, two steps per blend
  // ---------------------------------------------------------------------------
  logic [16:0]          mix_gain;
  logic signed [S-1:0]  mix_smp;
  logic signed [S+17:0] mix_prod;
  logic signed [MW-1:0] mix_sum;
  logic signed [MW-1:0] mix_sh;
  logic [S-1:0]         mix_res;

  always_comb begin
    mix_gain = 17'h0;
    mix_smp  = '0;
    unique case (state)
      mdc_pkg::ST_RD0: begin
        mix_gain = mdc_pkg::GAIN_ONE - {1'b0, lpf_alpha};
        mix_smp  = x_q;
      end
      mdc_pkg::ST_RD1: begin
        mix_gain = {1'b0, lpf_alpha};
        mix_smp  = lp;
      end
      mdc_pkg::ST_W1: begin
        mix_gain = mdc_pkg::GAIN_ONE - {1'b0, feedback_gain};
        mix_smp  = lp;
      end
      mdc_pkg::ST_W2: begin
        mix_gain = {1'b0, feedback_gain};
        mix_smp  = y_q;
      end
      mdc_pkg::ST_O1: begin
        mix_gain = mdc_pkg::GAIN_ONE - {1'b0, wet_mix};
        mix_smp  = x_q;
      end
      mdc_pkg::ST_O2: begin
        mix_gain = {1'b0, wet_mix};
        mix_smp  = y_q;
      end
      default: ;
    endcase
  end

  assign mix_prod = $signed({1'b0, mix_gain}) * mix_smp;
  assign mix_sum  = macc + MW'(mix_prod);
  assign mix_sh   = mix_sum >>> 16;
  assign mix_res  = sat_s(SATW'(mix_sh));

  // memory write: clearing pass or the feedback blend
  assign wr_en   = (state == mdc_pkg::ST_CLEAR) || (state == mdc_pkg::ST_W2);
  assign wr_addr = (state == mdc_pkg::ST_CLEAR) ? clr_addr : wp;
  assign wr_data = (state == mdc_pkg::ST_CLEAR) ? '0 : mix_res;

  mdc_delay_ram #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      base_delay    <= mdc_pkg::BASE_DELAY_RST;
      mod_depth     <= 16'h0;
      phase_step    <= 32'h0;
      wet_mix       <= mdc_pkg::WET_MIX_RST;
      feedback_gain <= 16'h0;
      lpf_alpha     <= 16'h0;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        mdc_pkg::REG_BASE_DELAY:    base_delay    <= cfg_wdata[11:0];
        mdc_pkg::REG_MOD_DEPTH:     mod_depth     <= cfg_wdata[15:0];
        mdc_pkg::REG_PHASE_STEP:    phase_step    <= cfg_wdata[31:0];
        mdc_pkg::REG_WET_MIX:       wet_mix       <= cfg_wdata[15:0];
        mdc_pkg::REG_FEEDBACK_GAIN: feedback_gain <= cfg_wdata[15:0];
        mdc_pkg::REG_LPF_ALPHA:     lpf_alpha     <= cfg_wdata[15:0];
        default: ;  // index beyond the register list is ignored
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer and control state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mdc_pkg::ST_CLEAR;
      clr_addr <= '0;
      wp       <= WP_RST;
      phase    <= 32'h0;
      lp       <= '0;
      m_valid  <= 1'b0;
    end else begin
      // output register: filled by the final step, freed by an output transaction
      if (out_load) begin
        m_valid <= 1'b1;
      end else if (m_tready) begin
        m_valid <= 1'b0;
      end
      unique case (state)
        mdc_pkg::ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == LAST_ADDR) begin
            state <= mdc_pkg::ST_IDLE;
          end
        end
        mdc_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            state <= mdc_pkg::ST_SIN1;
          end
        end
        mdc_pkg::ST_SIN1: state <= mdc_pkg::ST_SIN2;
        mdc_pkg::ST_SIN2: state <= mdc_pkg::ST_SIN3;
        mdc_pkg::ST_SIN3: state <= mdc_pkg::ST_SIN4;
        mdc_pkg::ST_SIN4: state <= mdc_pkg::ST_DMUL;
        mdc_pkg::ST_DMUL: state <= mdc_pkg::ST_DPOS;
        mdc_pkg::ST_DPOS: state <= mdc_pkg::ST_RD0;
        mdc_pkg::ST_RD0:  state <= mdc_pkg::ST_RD1;
        mdc_pkg::ST_RD1: begin
          // low-pass update shares the read window
          lp    <= mix_res;
          state <= mdc_pkg::ST_RD2;
        end
        mdc_pkg::ST_RD2:  state <= mdc_pkg::ST_RD3;
        mdc_pkg::ST_RD3:  state <= mdc_pkg::ST_RD4;
        mdc_pkg::ST_RD4:  state <= mdc_pkg::ST_COEF;
        mdc_pkg::ST_COEF: state <= mdc_pkg::ST_H1;
        mdc_pkg::ST_H1:   state <= mdc_pkg::ST_H2;
        mdc_pkg::ST_H2:   state <= mdc_pkg::ST_H3;
        mdc_pkg::ST_H3:   state <= mdc_pkg::ST_Y;
        mdc_pkg::ST_Y:    state <= mdc_pkg::ST_W1;
        mdc_pkg::ST_W1:   state <= mdc_pkg::ST_W2;
        mdc_pkg::ST_W2: begin
          // memory write happens this cycle, then pointer and lfo move on
          wp    <= (wp == LAST_ADDR) ? '0 : wp + AW'(1);
          phase <= phase + phase_step;
          state <= mdc_pkg::ST_O1;
        end
        mdc_pkg::ST_O1:   state <= mdc_pkg::ST_O2;
        mdc_pkg::ST_O2: begin
          // hold here until the output register is free
          if (out_load) begin
            state <= mdc_pkg::ST_IDLE;
          end
        end
        default: state <= mdc_pkg::ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // datapath registers, no reset
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    unique case (state)
      mdc_pkg::ST_IDLE: begin
        x_q <= $signed(s_tdata[S-1:0]);
      end
      mdc_pkg::ST_SIN1: begin
        sx    <= x_c;
        squad <= u[15:14];
        sx2   <= sm_sh[14:0];
      end
      mdc_pkg::ST_SIN2: st <= 16'(mdc_pkg::SIN_C2 - sm_sh[15:0]);
      mdc_pkg::ST_SIN3: st <= 16'(mdc_pkg::SIN_C3 - sm_sh[15:0]);
      mdc_pkg::ST_SIN4: begin
        // sign from the quadrant
        sine_q <= squad[1] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
      end
      mdc_pkg::ST_DMUL: dprod <= sine_q * $signed({1'b0, mod_depth});
      mdc_pkg::ST_DPOS: begin
        tap_base <= pos_w[AW-1:0];
        f_q      <= 8'(9'd256 - {1'b0, d_frac});
      end
      mdc_pkg::ST_RD0: macc <= MW'(mix_prod);
      mdc_pkg::ST_RD1: p0 <= $signed(rd_data);
      mdc_pkg::ST_RD2: p1 <= $signed(rd_data);
      mdc_pkg::ST_RD3: p2 <= $signed(rd_data);
      mdc_pkg::ST_RD4: p3 <= $signed(rd_data);
      mdc_pkg::ST_COEF: begin
        c3 <= (d12 <<< 1) + d12 + e3 - e0;
        c2 <= (e0 <<< 1) - ((e1 <<< 2) + e1) + (e2 <<< 2) - e3;
        c1 <= e2 - e0;
      end
      mdc_pkg::ST_H1: h <= (HW'(c2) <<< 8) + hmul;
      mdc_pkg::ST_H2: h <= (HW'(c1) <<< 16) + hmul;
      mdc_pkg::ST_H3: h <= hmul;
      mdc_pkg::ST_Y:  y_q <= sat_s(y_wide);
      mdc_pkg::ST_W1: macc <= MW'(mix_prod);
      mdc_pkg::ST_O1: macc <= MW'(mix_prod);
      mdc_pkg::ST_O2: begin
        if (out_load) begin
          out_q <= mix_res;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `MDC_ASSERT_NEXT(a_accept_starts, clk, rst, s_tvalid && s_tready, state == mdc_pkg::ST_SIN1, "accepted sample did not start the sequence")
  `MDC_ASSERT_SAME(a_result_from_end, clk, rst, $rose(m_tvalid), $past(state) == mdc_pkg::ST_O2, "result shown outside the final step")
  `MDC_ASSERT_NEXT(a_phase_moves_once, clk, rst, state != mdc_pkg::ST_W2, $stable(phase), "lfo phase moved outside the write step")

endmodule

FILE: src/mdc_delay_ram.sv
module mdc_delay_ram #(
  parameter int DELAY_DEPTH = mdc_pkg::DELAY_DEPTH_DEF,
  parameter int SAMPLE_BITS = mdc_pkg::SAMPLE_BITS_DEF,
  localparam int AW = $clog2(DELAY_DEPTH)
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [AW-1:0]          waddr,
  input  logic [SAMPLE_BITS-1:0] wdata,
  input  logic                   re,
  input  logic [AW-1:0]          raddr,
  output logic [SAMPLE_BITS-1:0] rdata
);

  logic [SAMPLE_BITS-1:0] mem [DELAY_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
